// ===== design/rotated_blit_address_generator_assert.svh =====
// assertion macros for the rotated blit address generator checker
// depends on a clk and an active-high rst signal in the including scope
`ifndef ROTATED_BLIT_ADDRESS_GENERATOR_ASSERT_SVH
`define ROTATED_BLIT_ADDRESS_GENERATOR_ASSERT_SVH

// property checked outside reset
`define RBAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds across reset
`define RBAG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rbag_pkg.sv =====
// shared types and constants of the rotated blit address generator
// no dependencies
`timescale 1ns / 1ps

package rbag_pkg;

  // default largest rectangle side in pixels
  localparam int MAX_DIM_DEF = 4096;

  // register port geometry
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int RECT_W    = 13;
  localparam int LINE_W    = 16;

  // cycles after a register write before the derived values are valid
  localparam int SETTLE_CYCLES = 3;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_QUADRANT       = 3'd0,
    REG_WIDE_PIXELS    = 3'd1,
    REG_RECT_WIDTH     = 3'd2,
    REG_RECT_HEIGHT    = 3'd3,
    REG_SRC_LINE_BYTES = 3'd4,
    REG_DST_LINE_BYTES = 3'd5,
    REG_SRC_BASE       = 3'd6,
    REG_DST_BASE       = 3'd7
  } rbag_reg_t;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } rbag_quad_t;

  typedef struct packed {
    logic [1:0]        quadrant;
    logic              wide_pixels;
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
    logic [LINE_W-1:0] src_line_bytes;
    logic [LINE_W-1:0] dst_line_bytes;
    logic [31:0]       src_base;
    logic [31:0]       dst_base;
  } rbag_cfg_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        frame_last;
  } rbag_result_t;

endpackage

// ===== design/rbag_step_core.sv =====
// address stepping core: derived step values from the registers and the
// running counters and pointers; depends on rbag_pkg
`timescale 1ns / 1ps

module rbag_step_core #(
  parameter int MAX_DIM = rbag_pkg::MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rbag_pkg::rbag_cfg_t  cfg,
  input  logic                 accept,
  input  logic [31:0]          pixel_in,
  output rbag_pkg::rbag_result_t result
);
  import rbag_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = (DIM_W > RECT_W) ? DIM_W : RECT_W;
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

  // size clamp: zero counts as one, above the limit counts as the limit
  logic [CMP_W-1:0] w_ext, h_ext, w_cl, h_cl;
  logic [DIM_W-1:0] w_c, h_c, w1_c, h1_c;
  logic [DIM_W+LINE_W-1:0] w1d_full, h1d_full;

  always_comb begin
    w_ext = CMP_W'(cfg.rect_width);
    h_ext = CMP_W'(cfg.rect_height);
    if (w_ext == '0) w_cl = CMP_W'(1);
    else if (w_ext > MAX_DIM_C) w_cl = MAX_DIM_C;
    else w_cl = w_ext;
    if (h_ext == '0) h_cl = CMP_W'(1);
    else if (h_ext > MAX_DIM_C) h_cl = MAX_DIM_C;
    else h_cl = h_ext;
    w_c  = DIM_W'(w_cl);
    h_c  = DIM_W'(h_cl);
    w1_c = w_c - DIM_W'(1);
    h1_c = h_c - DIM_W'(1);
    w1d_full = DIM_W'(w1_c) * (DIM_W+LINE_W)'(cfg.dst_line_bytes);
    h1d_full = DIM_W'(h1_c) * (DIM_W+LINE_W)'(cfg.dst_line_bytes);
  end

  // first derived stage: clamped sizes and products
  logic [DIM_W-1:0] dim_w, dim_h;
  logic [31:0]      w1d, h1d, w1p, h1p;

  always_ff @(posedge clk) begin
    dim_w <= w_c;
    dim_h <= h_c;
    w1d   <= 32'(w1d_full);
    h1d   <= 32'(h1d_full);
    w1p   <= cfg.wide_pixels ? 32'({w1_c, 2'b00}) : 32'({w1_c, 1'b0});
    h1p   <= cfg.wide_pixels ? 32'({h1_c, 2'b00}) : 32'({h1_c, 1'b0});
  end

  // second derived stage: per-quadrant start offset and step values
  logic [31:0] p32, d32;
  logic [31:0] start_next, x_add_next, dst_row_next;
  logic [31:0] start_off, x_add, dst_row_step, src_row_step;

  always_comb begin
    p32 = cfg.wide_pixels ? 32'd4 : 32'd2;
    d32 = 32'(cfg.dst_line_bytes);
    case (rbag_quad_t'(cfg.quadrant))
      QUAD_90: begin
        start_next   = w1d;
        x_add_next   = 32'd0 - d32;
        dst_row_next = p32 + w1d;
      end
      QUAD_180: begin
        start_next   = h1d + w1p;
        x_add_next   = 32'd0 - p32;
        dst_row_next = w1p - d32;
      end
      QUAD_270: begin
        start_next   = h1p;
        x_add_next   = d32;
        dst_row_next = 32'd0 - p32 - w1d;
      end
      default: begin
        start_next   = 32'd0;
        x_add_next   = p32;
        dst_row_next = d32 - w1p;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start_off    <= start_next;
    x_add        <= x_add_next;
    dst_row_step <= dst_row_next;
    src_row_step <= 32'(cfg.src_line_bytes) - w1p;
  end

  // third derived stage: destination start address
  logic [31:0] dst_start;

  always_ff @(posedge clk) begin
    dst_start <= cfg.dst_base + start_off;
  end

  // running state
  logic [CNT_W-1:0] col_count, row_count;
  logic [31:0]      src_pointer, dst_pointer;
  logic             frame_begin;

  logic [CNT_W-1:0] col_cur, row_cur;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic [31:0]      src_cur, dst_cur;
  logic             row_end, last;

  always_comb begin
    col_cur = frame_begin ? '0 : col_count;
    row_cur = frame_begin ? '0 : row_count;
    src_cur = frame_begin ? cfg.src_base : src_pointer;
    dst_cur = frame_begin ? dst_start : dst_pointer;
    col_inc = DIM_W'(col_cur) + DIM_W'(1);
    row_inc = DIM_W'(row_cur) + DIM_W'(1);
    row_end = col_inc >= dim_w;
    last    = row_end && (row_inc >= dim_h);
    result.pixel_out  = cfg.wide_pixels ? pixel_in : {16'd0, pixel_in[15:0]};
    result.src_addr   = src_cur;
    result.dst_addr   = dst_cur;
    result.frame_last = last;
  end

  // advance counters and pointers per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      src_pointer <= '0;
      dst_pointer <= '0;
      frame_begin <= 1'b1;
    end else if (accept) begin
      src_pointer <= src_cur + (row_end ? src_row_step : p32);
      dst_pointer <= dst_cur + (row_end ? dst_row_step : x_add);
      frame_begin <= last;
      if (row_end) begin
        col_count <= '0;
        row_count <= last ? '0 : CNT_W'(row_inc);
      end else begin
        col_count <= CNT_W'(col_inc);
        row_count <= row_cur;
      end
    end
  end

endmodule

// ===== design/rbag_out_skid.sv =====
// two-entry output buffer: result register plus skid register
// depends on rbag_pkg
`timescale 1ns / 1ps

module rbag_out_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rbag_pkg::rbag_result_t push_data,
  output logic                   push_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rbag_pkg::rbag_result_t out_data
);
  import rbag_pkg::*;

  rbag_result_t skid_data;
  logic         skid_valid;

  // upstream may push whenever the skid slot is empty
  assign push_ready = !skid_valid;

  // result slot refills from skid first, then from the new transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== design/rotated_blit_address_generator.sv =====
// top level of the rotated blit address generator: register port,
// settle timer, stepping core and output buffer; depends on rbag_pkg
`timescale 1ns / 1ps

// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// register  | psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
// pixel in  | in_valid/in_ready   | pixel_in
// result    | out_valid/out_ready | pixel_out, src_addr, dst_addr, frame_last
//
// one pixel per clock sustained while out_ready is high and no register write
// is settling; an accepted result is registered in the result register, or
// in the skid register while the held result waits, so input keeps flowing
// while one result waits; after reset and after each register write in_ready
// stays low while the three registered stages of derived step values refill
// reset is synchronous; counters restart at the first pixel of a frame

module rotated_blit_address_generator #(
  parameter int MAX_DIM = rbag_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbag_pkg::ADDR_W-1:0] paddr,
  input  logic [rbag_pkg::DATA_W-1:0] pwdata,
  output logic [rbag_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 pixel_out,
  output logic [31:0]                 src_addr,
  output logic [31:0]                 dst_addr,
  output logic                        frame_last
);
  import rbag_pkg::*;

  rbag_cfg_t    cfg;
  rbag_result_t step_result, out_data;
  rbag_reg_t    reg_idx;
  logic         cfg_write;
  logic [SETTLE_W-1:0] settle;
  logic         push_ready, accept;

  assign pready    = 1'b1;
  assign reg_idx   = rbag_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quadrant       <= '0;
      cfg.wide_pixels    <= 1'b0;
      cfg.rect_width     <= RECT_W'(1);
      cfg.rect_height    <= RECT_W'(1);
      cfg.src_line_bytes <= '0;
      cfg.dst_line_bytes <= '0;
      cfg.src_base       <= '0;
      cfg.dst_base       <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_QUADRANT:       cfg.quadrant       <= pwdata[1:0];
        REG_WIDE_PIXELS:    cfg.wide_pixels    <= pwdata[0];
        REG_RECT_WIDTH:     cfg.rect_width     <= pwdata[RECT_W-1:0];
        REG_RECT_HEIGHT:    cfg.rect_height    <= pwdata[RECT_W-1:0];
        REG_SRC_LINE_BYTES: cfg.src_line_bytes <= pwdata[LINE_W-1:0];
        REG_DST_LINE_BYTES: cfg.dst_line_bytes <= pwdata[LINE_W-1:0];
        REG_SRC_BASE:       cfg.src_base       <= pwdata;
        REG_DST_BASE:       cfg.dst_base       <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_QUADRANT:       prdata = DATA_W'(cfg.quadrant);
      REG_WIDE_PIXELS:    prdata = DATA_W'(cfg.wide_pixels);
      REG_RECT_WIDTH:     prdata = DATA_W'(cfg.rect_width);
      REG_RECT_HEIGHT:    prdata = DATA_W'(cfg.rect_height);
      REG_SRC_LINE_BYTES: prdata = DATA_W'(cfg.src_line_bytes);
      REG_DST_LINE_BYTES: prdata = DATA_W'(cfg.dst_line_bytes);
      REG_SRC_BASE:       prdata = cfg.src_base;
      REG_DST_BASE:       prdata = cfg.dst_base;
      default:            prdata = '0;
    endcase
  end

  // hold off input until derived step values are refreshed
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_W'(SETTLE_CYCLES);
    end else if (cfg_write) begin
      settle <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  assign in_ready = push_ready && (settle == '0);
  assign accept   = in_valid && in_ready;

  rbag_step_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .pixel_in (pixel_in),
    .result   (step_result)
  );

  rbag_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (step_result),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign pixel_out  = out_data.pixel_out;
  assign src_addr   = out_data.src_addr;
  assign dst_addr   = out_data.dst_addr;
  assign frame_last = out_data.frame_last;

endmodule

// ===== design/rbag_checker.sv =====
// port-level checks for the rotated blit address generator, bound to the top
// depends on rotated_blit_address_generator_assert.svh
`timescale 1ns / 1ps

module rbag_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] pixel_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_out,
  input logic [31:0] src_addr,
  input logic [31:0] dst_addr,
  input logic        frame_last
);

`include "rotated_blit_address_generator_assert.svh"

  // reset empties the output and blocks input
  `RBAG_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && !in_ready, "not idle after reset")

  // a register write blocks input while step values refresh
  `RBAG_ASSERT(a_cfg_blocks, psel && penable && pwrite && pready |=> !in_ready, "input open after write")

  // a transaction into an empty output shows up next cycle with its pixel
  `RBAG_ASSERT(a_pass_through, in_valid && in_ready && !out_valid |=> out_valid && pixel_out[15:0] == $past(pixel_in[15:0]), "pixel lost in buffer")

  // a stalled result holds
  `RBAG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(src_addr) && $stable(dst_addr) && $stable(pixel_out) && $stable(frame_last), "stalled result changed")

endmodule

bind rotated_blit_address_generator rbag_checker u_rbag_checker (.*);
